/* sv/tsrc_pkg.sv */
// ----------------------------------------------------------------------------
// tsrc_pkg
// Types, codes and helper functions of the two-rotor stepping cipher.
// ----------------------------------------------------------------------------
package tsrc_pkg;

  localparam int ROTOR_SIZE = 28;
  localparam int IDX_W      = 5;
  localparam int CHAR_W     = 8;
  localparam int OP_W       = 3;
  localparam int STATUS_W   = 2;
  localparam int CFG_ADDR_W = 1;

  localparam logic [CHAR_W-1:0] LOAD_KEY     = 8'd42;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_PERIOD  = 8'd46;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'd65;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'd97;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_NONE    = 8'd0;

  localparam logic [IDX_W-1:0] IDX_SPACE   = 5'd26;
  localparam logic [IDX_W-1:0] IDX_PERIOD  = 5'd27;
  localparam logic [IDX_W-1:0] IDX_LAST    = 5'(ROTOR_SIZE - 1);
  localparam logic [IDX_W-1:0] IDX_INVALID = 5'(ROTOR_SIZE);

  localparam logic [OP_W-1:0] OP_LOAD_RIGHT = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_LEFT  = 3'd1;
  localparam logic [OP_W-1:0] OP_ENCRYPT    = 3'd2;
  localparam logic [OP_W-1:0] OP_DECRYPT    = 3'd3;
  localparam logic [OP_W-1:0] OP_RESTART   = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_CHAR = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_START_RIGHT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_START_LEFT  = 1'd1;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CHAR_W-1:0]   char_t;
  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  function automatic idx_t mod_add(input idx_t a, input idx_t b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(ROTOR_SIZE)) begin
      s = s - (IDX_W+1)'(ROTOR_SIZE);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic idx_t mod_sub(input idx_t a, input idx_t b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + (IDX_W+1)'(ROTOR_SIZE) - {1'b0, b};
    if (s >= (IDX_W+1)'(ROTOR_SIZE)) begin
      s = s - (IDX_W+1)'(ROTOR_SIZE);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic idx_t mod_reduce(input idx_t a);
    return (a >= IDX_INVALID) ? idx_t'(a - IDX_INVALID) : a;
  endfunction

  function automatic idx_t sym_index(input char_t ch);
    char_t u;
    u = (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) ? char_t'(ch - CASE_OFFSET) : ch;
    if (ch == CHAR_SPACE) begin
      return IDX_SPACE;
    end else if (ch == CHAR_PERIOD) begin
      return IDX_PERIOD;
    end else if (u >= CHAR_UPPER_A && u <= CHAR_UPPER_Z) begin
      return idx_t'(u - CHAR_UPPER_A);
    end
    return IDX_INVALID;
  endfunction

  function automatic char_t sym_char(input idx_t idx);
    if (idx == IDX_SPACE) begin
      return CHAR_SPACE;
    end else if (idx == IDX_PERIOD) begin
      return CHAR_PERIOD;
    end
    return char_t'({3'b000, idx} + CHAR_UPPER_A);
  endfunction

endpackage

/* sv/tsrc_ifs.sv */
// ----------------------------------------------------------------------------
// tsrc channel interfaces
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface tsrc_in_if;
  logic                   valid;
  logic                   ready;
  tsrc_pkg::op_t          operation;
  tsrc_pkg::idx_t         entry_index;
  tsrc_pkg::char_t        entry_word;
  tsrc_pkg::char_t        char_in;

  modport source (output valid, operation, entry_index, entry_word, char_in, input ready);
  modport sink   (input valid, operation, entry_index, entry_word, char_in, output ready);
endinterface

interface tsrc_out_if;
  logic                   valid;
  logic                   ready;
  tsrc_pkg::char_t        char_out;
  tsrc_pkg::status_t      status;

  modport source (output valid, char_out, status, input ready);
  modport sink   (input valid, char_out, status, output ready);
endinterface

interface tsrc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [tsrc_pkg::CFG_ADDR_W-1:0]    addr;
  tsrc_pkg::idx_t                     data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

/* sv/two_rotor_stepping_cipher_top.sv */
// ----------------------------------------------------------------------------
// two_rotor_stepping_cipher_top
// Two-rotor stepping substitution cipher over A-Z, space and period.
// ----------------------------------------------------------------------------
// Usage:
//   din  : one transaction per request (load right/left entry, encrypt,
//          decrypt, restart). Loads and restart take effect on acceptance.
//   dout : exactly one result transaction per request (char_out, status).
//   cfg  : register writes (start_right, start_left), ready outside reset;
//          write only while the block is idle.
// Flow: loads, restart, newline and invalid characters go straight to the
//   output state after acceptance. Encrypt/decrypt runs one table lookup and a
//   search over the other rotor at one entry per cycle through a single
//   comparator, until a match or until every rotor entry has been compared.
//   din.ready is low while a request is in progress, so a new request is
//   taken only once the previous one has left the output state.
// Reset: offsets and start registers clear; rotor tables hold until loaded.
// Stall: the result sits in an output register; the next request is still
//   accepted and completes once dout frees the register.
// ----------------------------------------------------------------------------
module two_rotor_stepping_cipher_top (
  input  logic           clk,
  input  logic           rst,
  tsrc_in_if.sink        din,
  tsrc_out_if.source     dout,
  tsrc_cfg_if.sink       cfg
);
  import tsrc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_KEY  = 5'b00100,
    S_SRCH = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t  state;
  state_t  state_next;

  idx_t    start_right;
  idx_t    start_left;
  idx_t    right_offset;
  idx_t    left_offset;

  char_t   right_mem [ROTOR_SIZE];
  char_t   left_mem  [ROTOR_SIZE];
  char_t   right_rd;
  char_t   left_rd;
  idx_t    right_raddr;
  idx_t    left_raddr;

  logic    enc;
  idx_t    c_idx;
  idx_t    saddr;
  idx_t    srch_addr;
  idx_t    j;
  char_t   key;
  char_t   srch_data;
  char_t   res_char;
  status_t res_status;

  logic    out_valid;
  char_t   out_char;
  status_t out_status;

  logic    accept;
  logic    out_free;
  logic    load_right;
  logic    load_left;
  logic    is_cipher;
  idx_t    in_idx;

  assign din.ready     = (state == S_IDLE) && !rst;
  assign accept        = din.valid && din.ready;
  assign out_free      = !out_valid || dout.ready;
  assign dout.valid    = out_valid;
  assign dout.char_out = out_char;
  assign dout.status   = out_status;
  assign cfg.ready     = !rst;

  assign in_idx     = sym_index(din.char_in);
  assign is_cipher  = (din.operation == OP_ENCRYPT) || (din.operation == OP_DECRYPT);
  assign load_right = accept && (din.operation == OP_LOAD_RIGHT) && (din.entry_index < IDX_INVALID);
  assign load_left  = accept && (din.operation == OP_LOAD_LEFT) && (din.entry_index < IDX_INVALID);

  assign srch_addr   = (state == S_KEY) ? saddr : mod_add(saddr, idx_t'(1));
  assign right_raddr = (state == S_LOOK) ? mod_sub(c_idx, right_offset) : srch_addr;
  assign left_raddr  = (state == S_LOOK) ? mod_add(c_idx, left_offset) : srch_addr;
  assign srch_data   = enc ? left_rd : right_rd;

  always_ff @(posedge clk) begin
    if (load_right) begin
      right_mem[din.entry_index] <= din.entry_word ^ LOAD_KEY;
    end
    right_rd <= right_mem[right_raddr];
  end

  always_ff @(posedge clk) begin
    if (load_left) begin
      left_mem[din.entry_index] <= din.entry_word ^ LOAD_KEY;
    end
    left_rd <= left_mem[left_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_right <= '0;
      start_left  <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.addr)
        REG_START_RIGHT: start_right <= cfg.data;
        REG_START_LEFT:  start_left  <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if ((din.operation == OP_ENCRYPT || din.operation == OP_DECRYPT) &&
              din.char_in != CHAR_NEWLINE && in_idx != IDX_INVALID) begin
            state_next = S_LOOK;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_LOOK: state_next = S_KEY;
      S_KEY:  state_next = S_SRCH;
      S_SRCH: begin
        if (srch_data == key || j == IDX_LAST) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      right_offset <= '0;
      left_offset  <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && din.operation == OP_RESTART) begin
        right_offset <= mod_reduce(start_right);
        left_offset  <= mod_reduce(start_left);
      end else if (state == S_SRCH && srch_data == key) begin
        right_offset <= mod_add(right_offset, idx_t'(1));
        left_offset  <= mod_add(left_offset, idx_t'(1));
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      enc   <= (din.operation == OP_ENCRYPT);
      c_idx <= in_idx;
      saddr <= (din.operation == OP_ENCRYPT) ? left_offset : mod_sub('0, right_offset);
      if (is_cipher && din.char_in == CHAR_NEWLINE) begin
        res_char <= CHAR_NEWLINE;
      end else begin
        res_char <= CHAR_NONE;
      end
      if (is_cipher && din.char_in != CHAR_NEWLINE && in_idx == IDX_INVALID) begin
        res_status <= STATUS_BAD_CHAR;
      end else begin
        res_status <= STATUS_OK;
      end
    end
    if (state == S_KEY) begin
      key <= enc ? right_rd : left_rd;
      j   <= '0;
    end
    if (state == S_SRCH) begin
      saddr <= srch_addr;
      j     <= mod_add(j, idx_t'(1));
      if (srch_data == key) begin
        res_char <= sym_char(j);
      end else if (j == IDX_LAST) begin
        res_status <= STATUS_NO_MATCH;
      end
    end
    if (state == S_OUT && out_free) begin
      out_char   <= res_char;
      out_status <= res_status;
    end
  end

`ifndef NO_ASSERTIONS
  a_offsets_in_range: assert property (@(posedge clk) disable iff (rst)
    right_offset < IDX_INVALID && left_offset < IDX_INVALID)
    else $error("rotor offset out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !din.ready)
    else $error("request accepted while previous one in progress");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised outside output state");

  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SRCH |-> j <= IDX_LAST)
    else $error("search index ran past the rotor");

  a_offsets_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK || state == S_KEY) |=> $stable(right_offset) && $stable(left_offset))
    else $error("offsets changed before search finished");
`endif

endmodule
